### rtl/sphere_boundary_projection_core_macros.svh
// assertion helpers used by the checker file
`ifndef SPHERE_BOUNDARY_PROJECTION_CORE_MACROS_SVH
`define SPHERE_BOUNDARY_PROJECTION_CORE_MACROS_SVH

// antecedent implies consequent, sampled on clk, quiet in reset
`define SBP_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// condition never holds outside reset
`define SBP_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("assertion failed");

`endif

### rtl/sbp_pkg.sv
`default_nettype none
package sbp_pkg;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_CENTER_X     = 2'd0,
    REG_CENTER_Y     = 2'd1,
    REG_CENTER_Z     = 2'd2,
    REG_BOUND_RADIUS = 2'd3
  } reg_idx_t;

  // integer part of the container radius after reset
  localparam int RADIUS_RESET_INT = 10;

  // the three axes handled side by side in a divider cell
  localparam int LANES = 3;

endpackage
`default_nettype wire

### rtl/sbp_sqrt_cell.sv
`default_nettype none
// one bit of a digit-by-digit integer square root
module sbp_sqrt_cell #(
  parameter int ROOTW  = 33,
  parameter int SIDE_W = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire logic [2*ROOTW-1:0]   in_rad,
  input  wire logic [ROOTW-1:0]     in_root,
  input  wire logic [ROOTW:0]       in_rem,
  input  wire logic [SIDE_W-1:0]    in_side,
  output logic                      out_valid,
  output logic [2*ROOTW-1:0]        out_rad,
  output logic [ROOTW-1:0]          out_root,
  output logic [ROOTW:0]            out_rem,
  output logic [SIDE_W-1:0]         out_side
);

  logic [ROOTW+2:0] rem_ext;
  logic [ROOTW+2:0] trial;
  logic             take;
  logic [ROOTW+2:0] diff;

  // bring down two radicand bits and try the next root bit
  always_comb begin
    rem_ext = {in_rem, in_rad[2*ROOTW-1 -: 2]};
    trial   = {1'b0, in_root, 2'b01};
    take    = rem_ext >= trial;
    diff    = rem_ext - trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_rad  <= {in_rad[2*ROOTW-3:0], 2'b00};
    out_root <= {in_root[ROOTW-2:0], take};
    out_rem  <= take ? diff[ROOTW:0] : rem_ext[ROOTW:0];
    out_side <= in_side;
  end

endmodule
`default_nettype wire

### rtl/sbp_div_cell.sv
`default_nettype none
// one quotient bit of a restoring division, three axes sharing one divisor
module sbp_div_cell #(
  parameter int DIVW   = 33,
  parameter int LOWW   = 34,
  parameter int SIDE_W = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic [DIVW-1:0]   in_div,
  input  wire logic [DIVW-1:0]   in_rem [sbp_pkg::LANES],
  input  wire logic [LOWW-1:0]   in_low [sbp_pkg::LANES],
  input  wire logic [SIDE_W-1:0] in_side,
  output logic                   out_valid,
  output logic [DIVW-1:0]        out_div,
  output logic [DIVW-1:0]        out_rem [sbp_pkg::LANES],
  output logic [LOWW-1:0]        out_low [sbp_pkg::LANES],
  output logic [SIDE_W-1:0]      out_side
);

  logic [DIVW:0]   t    [sbp_pkg::LANES];
  logic            ge   [sbp_pkg::LANES];
  logic [DIVW:0]   diff [sbp_pkg::LANES];

  // shift in the next dividend bit and subtract where it fits
  always_comb begin
    for (int i = 0; i < sbp_pkg::LANES; i++) begin
      t[i]    = {in_rem[i], in_low[i][LOWW-1]};
      ge[i]   = t[i] >= {1'b0, in_div};
      diff[i] = t[i] - {1'b0, in_div};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < sbp_pkg::LANES; i++) begin
      out_rem[i] <= ge[i] ? diff[i][DIVW-1:0] : t[i][DIVW-1:0];
      out_low[i] <= {in_low[i][LOWW-2:0], ge[i]};
    end
    out_div  <= in_div;
    out_side <= in_side;
  end

endmodule
`default_nettype wire

### rtl/sphere_boundary_projection_core.sv
`default_nettype none
// Spherical container constraint: one particle per item, one item accepted
// every cycle (busy stays low). Each result appears on done in order, for
// one cycle; the receiver cannot stall, so results must be taken as they
// come. The path runs through the square-root cell chain (COORD_BITS+1 cells,
// one root bit each) and the divider cell chain (COORD_BITS+2 cells, one
// quotient bit each), plus six registered stages for differences, squares,
// sum, overshoot, products and saturation. Configuration writes go through
// the APB port and must only happen while no item is in flight.
module sphere_boundary_projection_core #(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   psel,
  input  wire logic                                   penable,
  input  wire logic                                   pwrite,
  input  wire logic [((COORD_BITS > 32) ? 5 : 4)-1:0] paddr,
  input  wire logic [((COORD_BITS > 32) ? 64 : 32)-1:0] pwdata,
  output logic [((COORD_BITS > 32) ? 64 : 32)-1:0]      prdata,
  output logic                                          pready,
  input  wire logic                                   start,
  output logic                                        busy,
  input  wire logic [COORD_BITS-1:0]                  pos_x,
  input  wire logic [COORD_BITS-1:0]                  pos_y,
  input  wire logic [COORD_BITS-1:0]                  pos_z,
  input  wire logic [COORD_BITS-2:0]                  particle_radius,
  output logic                                        done,
  output logic [COORD_BITS-1:0]                       new_x,
  output logic [COORD_BITS-1:0]                       new_y,
  output logic [COORD_BITS-1:0]                       new_z,
  output logic                                        pushed,
  output logic                                        degenerate
);

  localparam int CW     = COORD_BITS;
  localparam int RW     = CW - 1;
  localparam int AW     = (CW > 32) ? 5 : 4;
  localparam int PW     = (CW > 32) ? 64 : 32;
  localparam int SUMW   = 2 * CW + 2;
  localparam int ROOTW  = CW + 1;
  localparam int OVW    = CW + 2;
  localparam int PRODW  = CW + OVW;
  localparam int QW     = OVW;
  localparam int NW     = QW + 1;
  localparam int SQ_SW  = 6 * CW + 3 + RW;
  localparam int DV_SW  = 3 * CW + 5;
  localparam logic [RW-1:0] RAD_RESET = RW'(sbp_pkg::RADIUS_RESET_INT) << FRAC_BITS;

  // configuration registers
  logic [CW-1:0] cx, cy, cz;
  logic [RW-1:0] bound_rad;
  sbp_pkg::reg_idx_t reg_idx;

  assign reg_idx = sbp_pkg::reg_idx_t'(paddr[AW-1:AW-2]);
  assign pready  = 1'b1;
  assign busy    = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cx        <= '0;
      cy        <= '0;
      cz        <= '0;
      bound_rad <= RAD_RESET;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        sbp_pkg::REG_CENTER_X:     cx        <= pwdata[CW-1:0];
        sbp_pkg::REG_CENTER_Y:     cy        <= pwdata[CW-1:0];
        sbp_pkg::REG_CENTER_Z:     cz        <= pwdata[CW-1:0];
        sbp_pkg::REG_BOUND_RADIUS: bound_rad <= pwdata[RW-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_idx)
      sbp_pkg::REG_CENTER_X:     prdata = PW'(cx);
      sbp_pkg::REG_CENTER_Y:     prdata = PW'(cy);
      sbp_pkg::REG_CENTER_Z:     prdata = PW'(cz);
      sbp_pkg::REG_BOUND_RADIUS: prdata = PW'(bound_rad);
      default:                   prdata = '0;
    endcase
  end

  // stage 0: vector to center, split into sign and magnitude
  logic [CW:0] dx_f, dy_f, dz_f, ndx, ndy, ndz;
  always_comb begin
    dx_f = {cx[CW-1], cx} - {pos_x[CW-1], pos_x};
    dy_f = {cy[CW-1], cy} - {pos_y[CW-1], pos_y};
    dz_f = {cz[CW-1], cz} - {pos_z[CW-1], pos_z};
    ndx  = -dx_f;
    ndy  = -dy_f;
    ndz  = -dz_f;
  end

  logic          v0, v1, v2;
  logic [CW-1:0] px0, py0, pz0, ax0, ay0, az0;
  logic          sx0, sy0, sz0;
  logic [RW-1:0] pr0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v0 <= start && !busy;
      v1 <= v0;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    px0 <= pos_x;
    py0 <= pos_y;
    pz0 <= pos_z;
    pr0 <= particle_radius;
    sx0 <= dx_f[CW];
    sy0 <= dy_f[CW];
    sz0 <= dz_f[CW];
    ax0 <= dx_f[CW] ? ndx[CW-1:0] : dx_f[CW-1:0];
    ay0 <= dy_f[CW] ? ndy[CW-1:0] : dy_f[CW-1:0];
    az0 <= dz_f[CW] ? ndz[CW-1:0] : dz_f[CW-1:0];
  end

  // stage 1: squares of the magnitudes
  logic [2*CW-1:0]  qx1, qy1, qz1;
  logic [SQ_SW-1:0] side1, side2;

  always_ff @(posedge clk) begin
    qx1   <= ax0 * ax0;
    qy1   <= ay0 * ay0;
    qz1   <= az0 * az0;
    side1 <= {px0, py0, pz0, ax0, ay0, az0, sx0, sy0, sz0, pr0};
  end

  // stage 2: squared length
  logic [SUMW-1:0] sum2;
  always_ff @(posedge clk) begin
    sum2  <= SUMW'(qx1) + SUMW'(qy1) + SUMW'(qz1);
    side2 <= side1;
  end

  // square root cell chain
  logic               sq_v    [ROOTW+1];
  logic [SUMW-1:0]    sq_rad  [ROOTW+1];
  logic [ROOTW-1:0]   sq_root [ROOTW+1];
  logic [ROOTW:0]     sq_rem  [ROOTW+1];
  logic [SQ_SW-1:0]   sq_side [ROOTW+1];

  assign sq_v[0]    = v2;
  assign sq_rad[0]  = sum2;
  assign sq_root[0] = '0;
  assign sq_rem[0]  = '0;
  assign sq_side[0] = side2;

  for (genvar g = 0; g < ROOTW; g++) begin : g_sqrt
    sbp_sqrt_cell #(
      .ROOTW  (ROOTW),
      .SIDE_W (SQ_SW)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (sq_v[g]),
      .in_rad    (sq_rad[g]),
      .in_root   (sq_root[g]),
      .in_rem    (sq_rem[g]),
      .in_side   (sq_side[g]),
      .out_valid (sq_v[g+1]),
      .out_rad   (sq_rad[g+1]),
      .out_root  (sq_root[g+1]),
      .out_rem   (sq_rem[g+1]),
      .out_side  (sq_side[g+1])
    );
  end

  // unpack the side data at the end of the root chain
  logic [CW-1:0]    px_s, py_s, pz_s, ax_s, ay_s, az_s;
  logic             sx_s, sy_s, sz_s;
  logic [RW-1:0]    pr_s;
  logic [ROOTW-1:0] dist_s;
  logic [OVW-1:0]   reach_s;
  logic             hit_s;

  always_comb begin
    {px_s, py_s, pz_s, ax_s, ay_s, az_s, sx_s, sy_s, sz_s, pr_s} = sq_side[ROOTW];
    dist_s  = sq_root[ROOTW];
    reach_s = OVW'(dist_s) + OVW'(pr_s);
    hit_s   = reach_s > OVW'(bound_rad);
  end

  // stage 3: overshoot and flags
  logic             v3, v4;
  logic [OVW-1:0]   over3;
  logic [ROOTW-1:0] dist3, dist4;
  logic [CW-1:0]    ax3, ay3, az3;
  logic [DV_SW-1:0] side3, side4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v3 <= sq_v[ROOTW];
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    over3 <= reach_s - OVW'(bound_rad);
    dist3 <= dist_s;
    ax3   <= ax_s;
    ay3   <= ay_s;
    az3   <= az_s;
    side3 <= {px_s, py_s, pz_s, sx_s, sy_s, sz_s,
              hit_s && (dist_s != '0), hit_s && (dist_s == '0)};
  end

  // stage 4: magnitude times overshoot per axis
  logic [PRODW-1:0] prod4 [sbp_pkg::LANES];
  always_ff @(posedge clk) begin
    prod4[0] <= ax3 * over3;
    prod4[1] <= ay3 * over3;
    prod4[2] <= az3 * over3;
    dist4    <= dist3;
    side4    <= side3;
  end

  // divider cell chain
  logic             dv_v    [QW+1];
  logic [ROOTW-1:0] dv_div  [QW+1];
  logic [ROOTW-1:0] dv_rem  [QW+1][sbp_pkg::LANES];
  logic [QW-1:0]    dv_low  [QW+1][sbp_pkg::LANES];
  logic [DV_SW-1:0] dv_side [QW+1];

  assign dv_v[0]    = v4;
  assign dv_div[0]  = dist4;
  assign dv_side[0] = side4;
  for (genvar l = 0; l < sbp_pkg::LANES; l++) begin : g_lane
    assign dv_rem[0][l] = ROOTW'(prod4[l][PRODW-1:QW]);
    assign dv_low[0][l] = prod4[l][QW-1:0];
  end

  for (genvar g = 0; g < QW; g++) begin : g_div
    sbp_div_cell #(
      .DIVW   (ROOTW),
      .LOWW   (QW),
      .SIDE_W (DV_SW)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (dv_v[g]),
      .in_div    (dv_div[g]),
      .in_rem    (dv_rem[g]),
      .in_low    (dv_low[g]),
      .in_side   (dv_side[g]),
      .out_valid (dv_v[g+1]),
      .out_div   (dv_div[g+1]),
      .out_rem   (dv_rem[g+1]),
      .out_low   (dv_low[g+1]),
      .out_side  (dv_side[g+1])
    );
  end

  // apply the signed correction and clamp to the coordinate range
  function automatic logic [CW-1:0] move_sat(input logic [CW-1:0] p,
                                             input logic s,
                                             input logic [QW-1:0] q);
    logic signed [NW-1:0] n;
    logic signed [NW-1:0] hi;
    logic signed [NW-1:0] lo;
    n  = NW'($signed(p));
    n  = s ? n - $signed({1'b0, q}) : n + $signed({1'b0, q});
    hi = $signed({{(NW-CW+1){1'b0}}, {(CW-1){1'b1}}});
    lo = ~hi;
    if (n > hi) begin
      return {1'b0, {(CW-1){1'b1}}};
    end else if (n < lo) begin
      return {1'b1, {(CW-1){1'b0}}};
    end
    return n[CW-1:0];
  endfunction

  logic [CW-1:0] px_d, py_d, pz_d;
  logic          sx_d, sy_d, sz_d, push_d, degen_d;
  always_comb begin
    {px_d, py_d, pz_d, sx_d, sy_d, sz_d, push_d, degen_d} = dv_side[QW];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      done       <= 1'b0;
      pushed     <= 1'b0;
      degenerate <= 1'b0;
    end else begin
      done       <= dv_v[QW];
      pushed     <= dv_v[QW] && push_d;
      degenerate <= dv_v[QW] && degen_d;
    end
  end

  always_ff @(posedge clk) begin
    new_x <= push_d ? move_sat(px_d, sx_d, dv_low[QW][0]) : px_d;
    new_y <= push_d ? move_sat(py_d, sy_d, dv_low[QW][1]) : py_d;
    new_z <= push_d ? move_sat(pz_d, sz_d, dv_low[QW][2]) : pz_d;
  end

endmodule
`default_nettype wire

### rtl/sbp_checker.sv
`default_nettype none
`include "sphere_boundary_projection_core_macros.svh"
// port-level checks on the projection core
module sbp_checker #(
  parameter int COORD_BITS = 32
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic done,
  input wire logic pushed,
  input wire logic degenerate
);

  localparam int LAT = 2 * COORD_BITS + 9;

  // every accepted item is followed by its result on done
  `SBP_ASSERT_IMPLY(a_latency, start && !busy, ##LAT done)
  // no result without a matching item accepted earlier
  `SBP_ASSERT_IMPLY(a_no_spurious, done, $past(start && !busy, LAT))
  // flags only travel with a result
  `SBP_ASSERT_IMPLY(a_flags_idle, !done, !pushed && !degenerate)
  // an item is either moved or degenerate, never both
  `SBP_ASSERT_NEVER(a_flags_excl, pushed && degenerate)

endmodule

bind sphere_boundary_projection_core sbp_checker #(
  .COORD_BITS (COORD_BITS)
) u_sbp_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .done       (done),
  .pushed     (pushed),
  .degenerate (degenerate)
);
`default_nettype wire

### tb/tb_top.sv
`default_nettype none

// scoreboard for projected particle positions
class sphere_projection_board;
  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        pushed;
    logic        degenerate;
  } particle_out_t;

  logic [31:0]   ctr_x, ctr_y, ctr_z;
  logic [30:0]   radius;
  particle_out_t pending[$];
  int            mismatches;

  function new();
    ctr_x = '0;
    ctr_y = '0;
    ctr_z = '0;
    radius = 31'd655360;
    mismatches = 0;
  endfunction

  function void set_reg(sbp_pkg::reg_idx_t idx, logic [31:0] val);
    case (idx)
      sbp_pkg::REG_CENTER_X:     ctr_x = val;
      sbp_pkg::REG_CENTER_Y:     ctr_y = val;
      sbp_pkg::REG_CENTER_Z:     ctr_z = val;
      sbp_pkg::REG_BOUND_RADIUS: radius = val[30:0];
      default: ;
    endcase
  endfunction

  // shift one axis toward the center by its share of the overshoot, saturated
  function logic [31:0] shift_axis(longint p, longint d, longint unsigned over,
                                   longint unsigned seg_len);
    logic [127:0] prod;
    longint       q;
    longint       n;
    prod = 128'(d < 0 ? -d : d) * 128'(over);
    q = longint'(prod / 128'(seg_len));
    n = p + ((d < 0) ? -q : q);
    if (n > 64'sd2147483647) n = 64'sd2147483647;
    if (n < -64'sd2147483648) n = -64'sd2147483648;
    return n[31:0];
  endfunction

  // note an accepted particle and work out its projected position
  function void note_particle(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                              logic [30:0] pr);
    longint          dx, dy, dz;
    logic [127:0]    sq_sum;
    logic [127:0]    cand;
    longint unsigned seg_len, reach, over;
    particle_out_t   r;
    dx = longint'($signed(ctr_x)) - longint'($signed(px));
    dy = longint'($signed(ctr_y)) - longint'($signed(py));
    dz = longint'($signed(ctr_z)) - longint'($signed(pz));
    sq_sum = 128'(dx < 0 ? -dx : dx) * 128'(dx < 0 ? -dx : dx)
           + 128'(dy < 0 ? -dy : dy) * 128'(dy < 0 ? -dy : dy)
           + 128'(dz < 0 ? -dz : dz) * 128'(dz < 0 ? -dz : dz);
    // bitwise integer square root
    seg_len = 0;
    for (int b = 62; b >= 0; b--) begin
      cand = 128'(seg_len | (64'd1 << b));
      if (cand * cand <= sq_sum) seg_len = seg_len | (64'd1 << b);
    end
    reach = seg_len + 64'(pr);
    r.x = px;
    r.y = py;
    r.z = pz;
    r.pushed = 1'b0;
    r.degenerate = 1'b0;
    if (reach > 64'(radius)) begin
      over = reach - 64'(radius);
      if (seg_len == 0) begin
        r.degenerate = 1'b1;
      end else begin
        r.x = shift_axis(longint'($signed(px)), dx, over, seg_len);
        r.y = shift_axis(longint'($signed(py)), dy, over, seg_len);
        r.z = shift_axis(longint'($signed(pz)), dz, over, seg_len);
        r.pushed = 1'b1;
      end
    end
    pending.push_back(r);
  endfunction

  // compare one result with the oldest expectation
  function void check_result(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                             logic pu, logic dg);
    particle_out_t e;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result x=%h y=%h z=%h", x, y, z);
      return;
    end
    e = pending.pop_front();
    if (e.x !== x || e.y !== y || e.z !== z || e.pushed !== pu || e.degenerate !== dg)
    begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch exp x=%h y=%h z=%h p=%b d=%b got x=%h y=%h z=%h p=%b d=%b",
                 e.x, e.y, e.z, e.pushed, e.degenerate, x, y, z, pu, dg);
    end
  endfunction
endclass

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 2 * 32 + 9;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic [30:0] particle_radius = '0;
  logic        done;
  logic [31:0] new_x, new_y, new_z;
  logic        pushed, degenerate;

  sphere_projection_board board = new();
  int  cycles = 0;
  bit  no_gaps = 1'b0;

  sphere_boundary_projection_core i_dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .start(start), .busy(busy), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .particle_radius(particle_radius), .done(done), .new_x(new_x),
    .new_y(new_y), .new_z(new_z), .pushed(pushed), .degenerate(degenerate)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // accepted items and results
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && start && !busy) board.note_particle(pos_x, pos_y, pos_z, particle_radius);
    if (!rst && done) board.check_result(new_x, new_y, new_z, pushed, degenerate);
  end

  // run limit
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // apb write, setup then access
  task automatic write_reg(sbp_pkg::reg_idx_t idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    board.set_reg(idx, val);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_container(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                               logic [30:0] rad);
    write_reg(sbp_pkg::REG_CENTER_X, cx);
    write_reg(sbp_pkg::REG_CENTER_Y, cy);
    write_reg(sbp_pkg::REG_CENTER_Z, cz);
    write_reg(sbp_pkg::REG_BOUND_RADIUS, {1'b0, rad});
    @(posedge clk);
  endtask

  // one item, start kept high across back-to-back items
  task automatic send_particle(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                               logic [30:0] pr);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    pos_x <= px;
    pos_y <= py;
    pos_z <= pz;
    particle_radius <= pr;
    do @(posedge clk); while (busy);
  endtask

  // drain everything in flight
  task automatic drain();
    start <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  // random offset around the center, mostly near the boundary scale
  function automatic logic [31:0] near_coord(logic [31:0] c, logic [30:0] rad);
    int unsigned span;
    span = (rad > 31'd100000000) ? 32'd200000000 : 32'(rad) * 2 + 16;
    return c + $urandom_range(0, span) - span / 2;
  endfunction

  task automatic random_particles(int count);
    logic [31:0] px, py, pz;
    logic [30:0] pr;
    int          kind;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        px = near_coord(board.ctr_x, board.radius);
        py = near_coord(board.ctr_y, board.radius);
        pz = near_coord(board.ctr_z, board.radius);
        pr = $urandom_range(0, 3) == 0 ? 31'($urandom) : 31'($urandom_range(0, 200000));
      end else if (kind < 9) begin
        px = $urandom;
        py = $urandom;
        pz = $urandom;
        pr = 31'($urandom);
      end else begin
        // particle sitting exactly at the center
        px = board.ctr_x;
        py = board.ctr_y;
        pz = board.ctr_z;
        pr = 31'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 1000));
      end
      send_particle(px, py, pz, pr);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset container (center 0, radius 10.0)
    send_particle(32'h0, 32'h0, 32'h0, 31'h0);
    send_particle(32'h0, 32'h0, 32'h0, 31'd655361);
    send_particle(32'h0, 32'h0, 32'h0, 31'h7fffffff);
    send_particle(32'h000a0000, 32'h0, 32'h0, 31'h0);
    send_particle(32'h000a0001, 32'h0, 32'h0, 31'h0);
    send_particle(32'h0, 32'hfff5ffff, 32'h0, 31'h0);
    send_particle(32'h00070000, 32'h00070000, 32'h00070000, 31'h0);
    send_particle(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 31'h7fffffff);
    send_particle(32'h80000000, 32'h80000000, 32'h80000000, 31'h7fffffff);
    send_particle(32'h80000000, 32'h7fffffff, 32'h0, 31'h0);
    send_particle(32'h00000001, 32'h00000000, 32'h00000000, 31'd655360);
    send_particle(32'h00000000, 32'h00000000, 32'hffffffff, 31'd655360);
    // large overshoot far away, deltas round to zero on some axes
    send_particle(32'h40000000, 32'h00000001, 32'h0, 31'h0);
    drain();

    // container at extremes, saturation on the way back
    set_container(32'h7fffffff, 32'h80000000, 32'h7fffffff, 31'h0);
    send_particle(32'h80000000, 32'h7fffffff, 32'h80000000, 31'h7fffffff);
    send_particle(32'h7fffffff, 32'h80000000, 32'h7fffffff, 31'h0);
    send_particle(32'h7fffffff, 32'h80000000, 32'h7fffffff, 31'h1);
    send_particle(32'h7ffffffe, 32'h80000000, 32'h7fffffff, 31'h0);
    random_particles(300);
    drain();

    set_container(32'h80000000, 32'h7fffffff, 32'h80000000, 31'h7fffffff);
    send_particle(32'h7fffffff, 32'h80000000, 32'h7fffffff, 31'h7fffffff);
    send_particle(32'h80000000, 32'h7fffffff, 32'h80000000, 31'h7fffffff);
    random_particles(300);
    drain();

    set_container(32'h0, 32'h0, 32'h0, 31'h0);
    random_particles(300);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      set_container($urandom_range(0, 1) ? $urandom : $urandom_range(0, 2000000) - 1000000,
                    $urandom_range(0, 1) ? $urandom : $urandom_range(0, 2000000) - 1000000,
                    $urandom_range(0, 1) ? $urandom : $urandom_range(0, 2000000) - 1000000,
                    $urandom_range(0, 1) ? 31'($urandom) : 31'($urandom_range(0, 5000000)));
      random_particles(300);
      drain();
    end

    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

`default_nettype wire

### filelist.f
+incdir+rtl
rtl/sbp_pkg.sv
rtl/sbp_sqrt_cell.sv
rtl/sbp_div_cell.sv
rtl/sphere_boundary_projection_core.sv
rtl/sbp_checker.sv
tb/tb_top.sv
